### rtl/core/chebyshev_tensor_eval_3d_top_defines.svh
// ---------------------------------------------------------------------------
// chebyshev_tensor_eval_3d_top_defines
// Shared assertion macros for the evaluator core.
// ---------------------------------------------------------------------------
// each macro expects clk and rst_n in scope
`ifndef CHEBYSHEV_TENSOR_EVAL_3D_TOP_DEFINES_SVH
`define CHEBYSHEV_TENSOR_EVAL_3D_TOP_DEFINES_SVH

// same-cycle implication
`define CTE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cte: same-cycle check failed");

// next-cycle implication
`define CTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cte: next-cycle check failed");

`endif

### rtl/core/cte_pkg.sv
// ---------------------------------------------------------------------------
// cte_pkg
// Shared constants, command/status types and rounding helpers for the
// trivariate Chebyshev series evaluator.
// ---------------------------------------------------------------------------
`default_nettype none

package cte_pkg;

    localparam int FIRST_ORDER  = 16;
    localparam int SECOND_ORDER = 16;
    localparam int THIRD_ORDER  = 16;
    localparam int NODES_MAX    = 32;

    localparam int BLOCK     = FIRST_ORDER * SECOND_ORDER * THIRD_ORDER;
    localparam int MAX_ORDER = (FIRST_ORDER > SECOND_ORDER)
        ? ((FIRST_ORDER > THIRD_ORDER) ? FIRST_ORDER : THIRD_ORDER)
        : ((SECOND_ORDER > THIRD_ORDER) ? SECOND_ORDER : THIRD_ORDER);
    localparam int ORD_W = $clog2(MAX_ORDER + 1);
    localparam int FX_W  = (FIRST_ORDER > 1) ? $clog2(FIRST_ORDER) : 1;
    localparam int FY_W  = (SECOND_ORDER > 1) ? $clog2(SECOND_ORDER) : 1;
    localparam int FZ_W  = (THIRD_ORDER > 1) ? $clog2(THIRD_ORDER) : 1;

    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = 17;
    localparam int COORD_W     = 32;
    localparam int COEF_W      = 32;
    localparam int VAL_W       = 48;
    localparam int NODE_W      = 5;
    localparam int CNT_W       = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_W       = 32;
    localparam int T_W         = 32;

    localparam int NODE_CAP_I = (NODES_MAX < 32) ? NODES_MAX : 32;
    localparam logic [CNT_W-1:0] NODE_CAP = CNT_W'(NODE_CAP_I);

    localparam int DIVD_W = 64;
    localparam int DIVS_W = 32;
    localparam int QUO_W  = 31;

    localparam int ACC_RAW = 34 + $clog2(BLOCK);
    localparam int ACC_W   = (ACC_RAW > VAL_W) ? ACC_RAW : VAL_W + 1;

    localparam logic signed [T_W-1:0] ONE_Q30 = 32'sh4000_0000;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_N = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_PHS_N = 3'd7;

    typedef struct packed {
        logic cap_eval;
        logic rs_start;
        logic rs_store;
        logic cheb_mul;
        logic cheb_fin;
        logic node_init;
        logic w0;
        logic w1;
        logic issue;
        logic emit;
    } cte_cmd_t;

    typedef struct packed {
        logic div_done;
        logic rs_last;
        logic cheb_last;
        logic total_zero;
        logic k_last;
        logic ij_last;
        logic pipe_empty;
        logic node_last;
        logic out_free;
    } cte_sts_t;

    // round to nearest, ties away from zero
    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                    input int unsigned s);
        logic [63:0] h;
        logic [63:0] m;
        h = 64'd1 << (s - 1);
        if (v >= 0)
            return $signed(($unsigned(v) + h) >> s);
        m = $unsigned(-v);
        return -$signed((m + h) >> s);
    endfunction

    function automatic logic signed [T_W-1:0] sat_unit(input logic signed [63:0] v);
        if (v > 64'sh4000_0000)
            return ONE_Q30;
        if (v < -64'sh4000_0000)
            return -ONE_Q30;
        return v[T_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/chebyshev_tensor_eval_3d_top.sv
// ---------------------------------------------------------------------------
// chebyshev_tensor_eval_3d_top
// Trivariate Chebyshev series evaluator over a stored coefficient set.
// ---------------------------------------------------------------------------
// usage
//  - input channel (in_valid/in_stall): func 0 is a coefficient write straight
//    into the RAM; func 1 is an evaluation at three Q16.16 coordinates
//  - output channel (out_valid/out_stall): one transfer per node, amplitude
//    nodes first, then phase nodes, last_result on the final one
//  - config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready,
//    write only while no evaluation is running
//  - evaluation: three divider passes, one per axis, then the tables are
//    built; each node then runs through the single multiply-accumulate
//    pipe over the coefficient RAM port
//  - no further input is taken until the last result has been loaded
//  - a stalled receiver holds the result register, the sequencer waits
//  - reset restores the register defaults; the coefficient RAM is not
//    cleared and must be written before it is read
// ---------------------------------------------------------------------------
`default_nettype none

module chebyshev_tensor_eval_3d_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              func,
    input  logic [cte_pkg::ADDR_W-1:0]        coef_address,
    input  logic signed [cte_pkg::COEF_W-1:0] coef_value,
    input  logic [cte_pkg::COORD_W-1:0]       first_coord,
    input  logic [cte_pkg::COORD_W-1:0]       second_coord,
    input  logic [cte_pkg::COORD_W-1:0]       third_coord,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              result_kind,
    output logic [cte_pkg::NODE_W-1:0]        node_number,
    output logic signed [cte_pkg::VAL_W-1:0]  node_value,
    output logic                              range_flag,
    output logic                              last_result,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cte_pkg::CFG_W-1:0]         cfg_data
);
    import cte_pkg::*;

    cte_cmd_t cmd;
    cte_sts_t sts;
    logic     store_we;

    // config writes complete every cycle
    assign cfg_ready = 1'b1;

    // coefficient write transfer goes straight into the RAM
    assign store_we = in_valid && !in_stall && !func;

    cte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .func     (func),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    cte_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .store_we     (store_we),
        .coef_address (coef_address),
        .coef_value   (coef_value),
        .first_coord  (first_coord),
        .second_coord (second_coord),
        .third_coord  (third_coord),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .result_kind  (result_kind),
        .node_number  (node_number),
        .node_value   (node_value),
        .range_flag   (range_flag),
        .last_result  (last_result)
    );

endmodule

`default_nettype wire

### rtl/core/cte_ram.sv
// ---------------------------------------------------------------------------
// cte_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module cte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/core/cte_div.sv
// ---------------------------------------------------------------------------
// cte_div
// Restoring divider, one quotient bit per cycle, for coordinate rescaling.
// ---------------------------------------------------------------------------
`default_nettype none

module cte_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [cte_pkg::DIVD_W-1:0] dividend,
    input  logic [cte_pkg::DIVS_W-1:0] divisor,
    output logic                       done,
    output logic [cte_pkg::QUO_W-1:0]  quotient
);
    import cte_pkg::*;

    localparam int STEP_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVD_W-1:0] dq_reg, dq_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W+1:0] diff;

    always_comb
    begin
        shifted   = {rem_reg, dq_reg[DIVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dq_next   = dq_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = '0;
            rem_next  = '0;
            dq_next   = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DIVS_W+1])
            begin
                rem_next = diff[DIVS_W-1:0];
            end
            else
            begin
                rem_next = shifted[DIVS_W-1:0];
            end
            dq_next  = {dq_reg[DIVD_W-2:0], ~diff[DIVS_W+1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == STEP_W'(DIVD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dq_reg  <= dq_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = dq_reg[QUO_W-1:0];

endmodule

`default_nettype wire

### rtl/core/cte_datapath.sv
// ---------------------------------------------------------------------------
// cte_datapath
// Register file, rescaling, Chebyshev tables, MAC pipeline and result register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "chebyshev_tensor_eval_3d_top_defines.svh"

module cte_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cte_pkg::cte_cmd_t                  cmd,
    output cte_pkg::cte_sts_t                  sts,
    input  logic                               cfg_we,
    input  logic [cte_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cte_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               store_we,
    input  logic [cte_pkg::ADDR_W-1:0]         coef_address,
    input  logic signed [cte_pkg::COEF_W-1:0]  coef_value,
    input  logic [cte_pkg::COORD_W-1:0]        first_coord,
    input  logic [cte_pkg::COORD_W-1:0]        second_coord,
    input  logic [cte_pkg::COORD_W-1:0]        third_coord,
    input  logic                               out_stall,
    output logic                               out_valid,
    output logic                               result_kind,
    output logic [cte_pkg::NODE_W-1:0]         node_number,
    output logic signed [cte_pkg::VAL_W-1:0]   node_value,
    output logic                               range_flag,
    output logic                               last_result
);
    import cte_pkg::*;

    // configuration
    logic [COORD_W-1:0] amin_reg [3];
    logic [COORD_W-1:0] amax_reg [3];
    logic [CNT_W-1:0]   acnt_reg, pcnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amin_reg[0] <= 32'd32768;
            amax_reg[0] <= 32'd65536;
            amin_reg[1] <= 32'd3276800;
            amax_reg[1] <= 32'd327680000;
            amin_reg[2] <= 32'd3276800;
            amax_reg[2] <= 32'd327680000;
            acnt_reg    <= 6'd12;
            pcnt_reg    <= 6'd7;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_X_MIN: amin_reg[0] <= cfg_data;
                REG_X_MAX: amax_reg[0] <= cfg_data;
                REG_Y_MIN: amin_reg[1] <= cfg_data;
                REG_Y_MAX: amax_reg[1] <= cfg_data;
                REG_Z_MIN: amin_reg[2] <= cfg_data;
                REG_Z_MAX: amax_reg[2] <= cfg_data;
                REG_AMP_N: acnt_reg    <= cfg_data[CNT_W-1:0];
                REG_PHS_N: pcnt_reg    <= cfg_data[CNT_W-1:0];
                default:   acnt_reg    <= acnt_reg;
            endcase
        end
    end

    // coefficient store
    logic [ADDR_W-1:0] addr_reg;
    logic [COEF_W-1:0] rdata;

    cte_ram #(
        .WIDTH (COEF_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (store_we),
        .waddr (coef_address),
        .wdata (coef_value),
        .raddr (addr_reg),
        .rdata (rdata)
    );

    // evaluation setup
    logic [COORD_W-1:0] coord_reg [3];
    logic [CNT_W-1:0]   na_reg, total_reg, node_reg;
    logic [CNT_W-1:0]   na_c, np_c, room_c;
    logic               flag_reg;
    logic [1:0]         ax_reg;

    always_comb
    begin
        na_c   = (acnt_reg < NODE_CAP) ? acnt_reg : NODE_CAP;
        room_c = NODE_CAP - na_c;
        np_c   = (pcnt_reg < room_c) ? pcnt_reg : room_c;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_eval)
        begin
            coord_reg[0] <= first_coord;
            coord_reg[1] <= second_coord;
            coord_reg[2] <= third_coord;
        end
    end

    // rescaling onto [-1,1]
    logic [COORD_W-1:0]  c_s, lo_s, hi_s, cc, den;
    logic                degen, outside, neg;
    logic signed [33:0]  num;
    logic [32:0]         mag;
    logic [DIVD_W-1:0]   dividend;
    logic                div_done;
    logic [QUO_W-1:0]    quo;
    logic signed [T_W-1:0] r_new;
    logic signed [T_W-1:0] r_reg [3];

    always_comb
    begin
        c_s     = coord_reg[ax_reg];
        lo_s    = amin_reg[ax_reg];
        hi_s    = amax_reg[ax_reg];
        degen   = (hi_s <= lo_s);
        outside = degen ? (c_s != lo_s) : ((c_s < lo_s) || (c_s > hi_s));
        if (c_s < lo_s)
            cc = lo_s;
        else if (c_s > hi_s)
            cc = hi_s;
        else
            cc = c_s;
        num = $signed({1'b0, cc, 1'b0}) - $signed({2'b00, lo_s})
            - $signed({2'b00, hi_s});
        neg = num[33];
        mag = neg ? 33'(-num) : num[32:0];
        den = hi_s - lo_s;
        dividend = ({31'd0, mag} << 30) + {33'd0, den[COORD_W-1:1]};
        if (degen)
            r_new = '0;
        else if (neg)
            r_new = -$signed({1'b0, quo});
        else
            r_new = $signed({1'b0, quo});
    end

    cte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.rs_start),
        .dividend (dividend),
        .divisor  (den),
        .done     (div_done),
        .quotient (quo)
    );

    // Chebyshev tables
    logic [ORD_W-1:0]       n_reg, ord_sel;
    logic signed [T_W-1:0]  prev1_reg, prev2_reg, x_sel, t_new;
    logic signed [63:0]     cprod_reg;
    logic signed [T_W-1:0]  tx_reg [FIRST_ORDER];
    logic signed [T_W-1:0]  ty_reg [SECOND_ORDER];
    logic signed [T_W-1:0]  tz_reg [THIRD_ORDER];

    always_comb
    begin
        x_sel = r_reg[ax_reg];
        case (ax_reg)
            2'd0:    ord_sel = ORD_W'(FIRST_ORDER);
            2'd1:    ord_sel = ORD_W'(SECOND_ORDER);
            default: ord_sel = ORD_W'(THIRD_ORDER);
        endcase
        if (n_reg == '0)
            t_new = ONE_Q30;
        else if (n_reg == ORD_W'(1))
            t_new = x_sel;
        else
            t_new = sat_unit(rnd_shift(cprod_reg, 29) - 64'(prev2_reg));
    end

    // MAC loop
    logic [ORD_W-1:0]       i_reg, j_reg, k_reg;
    logic signed [63:0]     wprod_reg, p1_reg, p2_reg;
    logic signed [T_W-1:0]  wij_reg, tzk_reg, w_s2;
    logic signed [COEF_W-1:0] c_reg;
    logic                   v1_reg, v2_reg, v3_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [63:0]     term;
    logic                   k_last, j_last, i_last;

    assign k_last = (k_reg == ORD_W'(THIRD_ORDER - 1));
    assign j_last = (j_reg == ORD_W'(SECOND_ORDER - 1));
    assign i_last = (i_reg == ORD_W'(FIRST_ORDER - 1));
    assign w_s2   = T_W'(rnd_shift(p1_reg, 30));
    assign term   = rnd_shift(p2_reg, 30);

    // result register
    logic               ov_reg, kind_reg, rflag_reg, last_reg;
    logic [NODE_W-1:0]  num_reg;
    logic signed [VAL_W-1:0] val_reg, val_sat;
    logic               ovf, out_free;

    assign ovf = (acc_reg[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){1'b0}})
              && (acc_reg[ACC_W-1:VAL_W-1] != {(ACC_W-VAL_W+1){1'b1}});
    assign val_sat = ovf ? (acc_reg[ACC_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                             : {1'b0, {(VAL_W-1){1'b1}}})
                         : acc_reg[VAL_W-1:0];
    assign out_free = !ov_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ax_reg    <= '0;
            n_reg     <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            k_reg     <= '0;
            node_reg  <= '0;
            na_reg    <= '0;
            total_reg <= '0;
            flag_reg  <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            ov_reg    <= 1'b0;
            addr_reg  <= '0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (cmd.cap_eval)
            begin
                na_reg    <= na_c;
                total_reg <= na_c + np_c;
                node_reg  <= '0;
                flag_reg  <= 1'b0;
                ax_reg    <= '0;
                n_reg     <= '0;
                addr_reg  <= '0;
            end
            if (cmd.rs_store)
            begin
                flag_reg <= flag_reg | outside;
                ax_reg   <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
            end
            if (cmd.cheb_fin)
            begin
                if (n_reg == ord_sel - 1'b1)
                begin
                    n_reg  <= '0;
                    ax_reg <= (ax_reg == 2'd2) ? 2'd0 : ax_reg + 2'd1;
                end
                else
                begin
                    n_reg <= n_reg + 1'b1;
                end
            end
            if (cmd.node_init)
            begin
                i_reg <= '0;
                j_reg <= '0;
                k_reg <= '0;
            end
            if (cmd.issue)
            begin
                addr_reg <= addr_reg + 1'b1;
                if (k_last)
                begin
                    k_reg <= '0;
                    if (j_last)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                    else
                    begin
                        j_reg <= j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_reg <= k_reg + 1'b1;
                end
            end
            if (cmd.emit)
            begin
                ov_reg   <= 1'b1;
                node_reg <= node_reg + 1'b1;
            end
            else if (ov_reg && !out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rs_store)
        begin
            r_reg[ax_reg] <= r_new;
        end
        if (cmd.cheb_mul)
        begin
            cprod_reg <= $signed(x_sel) * $signed(prev1_reg);
        end
        if (cmd.cheb_fin)
        begin
            prev2_reg <= prev1_reg;
            prev1_reg <= t_new;
            case (ax_reg)
                2'd0:    tx_reg[n_reg[FX_W-1:0]] <= t_new;
                2'd1:    ty_reg[n_reg[FY_W-1:0]] <= t_new;
                default: tz_reg[n_reg[FZ_W-1:0]] <= t_new;
            endcase
        end
        if (cmd.w0)
        begin
            wprod_reg <= $signed(tx_reg[i_reg[FX_W-1:0]]) * $signed(ty_reg[j_reg[FY_W-1:0]]);
        end
        if (cmd.w1)
        begin
            wij_reg <= T_W'(rnd_shift(wprod_reg, 30));
        end
        if (cmd.issue)
        begin
            tzk_reg <= tz_reg[k_reg[FZ_W-1:0]];
        end
        if (v1_reg)
        begin
            p1_reg <= $signed(wij_reg) * $signed(tzk_reg);
            c_reg  <= rdata;
        end
        if (v2_reg)
        begin
            p2_reg <= $signed(c_reg) * $signed(w_s2);
        end
        if (cmd.node_init)
        begin
            acc_reg <= '0;
        end
        else if (v3_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
        if (cmd.emit)
        begin
            kind_reg  <= (node_reg >= na_reg);
            num_reg   <= (node_reg >= na_reg) ? NODE_W'(node_reg - na_reg)
                                              : node_reg[NODE_W-1:0];
            val_reg   <= val_sat;
            rflag_reg <= flag_reg;
            last_reg  <= (node_reg == total_reg - 1'b1);
        end
    end

    always_comb
    begin
        sts.div_done   = div_done;
        sts.rs_last    = (ax_reg == 2'd2);
        sts.cheb_last  = (ax_reg == 2'd2) && (n_reg == ord_sel - 1'b1);
        sts.total_zero = (total_reg == '0);
        sts.k_last     = k_last;
        sts.ij_last    = i_last && j_last;
        sts.pipe_empty = !v1_reg && !v2_reg && !v3_reg;
        sts.node_last  = (node_reg == total_reg - 1'b1);
        sts.out_free   = out_free;
    end

    assign out_valid   = ov_reg;
    assign result_kind = kind_reg;
    assign node_number = num_reg;
    assign node_value  = val_reg;
    assign range_flag  = rflag_reg;
    assign last_result = last_reg;

    `CTE_ASSERT_NOW(a_emit_drained, cmd.emit, !v1_reg && !v2_reg && !v3_reg)
    `CTE_ASSERT_NOW(a_emit_no_overwrite, cmd.emit, !ov_reg || !out_stall)
    `CTE_ASSERT_NOW(a_store_after_div, cmd.rs_store, div_done && !cmd.rs_start)
    `CTE_ASSERT_NEXT(a_mul_then_fin, cmd.cheb_mul, cmd.cheb_fin && !cmd.issue)

endmodule

`default_nettype wire

### rtl/core/cte_ctrl.sv
// ---------------------------------------------------------------------------
// cte_ctrl
// Sequencer for write and evaluate transfers.
// ---------------------------------------------------------------------------
`default_nettype none

module cte_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              func,
    output logic              in_stall,
    output cte_pkg::cte_cmd_t cmd,
    input  cte_pkg::cte_sts_t sts
);
    import cte_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_RS_GO   = 4'd1;
    localparam logic [3:0] S_RS_WAIT = 4'd2;
    localparam logic [3:0] S_CH_MUL  = 4'd3;
    localparam logic [3:0] S_CH_FIN  = 4'd4;
    localparam logic [3:0] S_N_CHK   = 4'd5;
    localparam logic [3:0] S_N_INIT  = 4'd6;
    localparam logic [3:0] S_W0      = 4'd7;
    localparam logic [3:0] S_W1      = 4'd8;
    localparam logic [3:0] S_STREAM  = 4'd9;
    localparam logic [3:0] S_DRAIN   = 4'd10;
    localparam logic [3:0] S_EMIT    = 4'd11;

    logic [3:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && func)
                begin
                    cmd.cap_eval = 1'b1;
                    state_next   = S_RS_GO;
                end
            end
            S_RS_GO:
            begin
                cmd.rs_start = 1'b1;
                state_next   = S_RS_WAIT;
            end
            S_RS_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.rs_store = 1'b1;
                    state_next   = sts.rs_last ? S_CH_MUL : S_RS_GO;
                end
            end
            S_CH_MUL:
            begin
                cmd.cheb_mul = 1'b1;
                state_next   = S_CH_FIN;
            end
            S_CH_FIN:
            begin
                cmd.cheb_fin = 1'b1;
                state_next   = sts.cheb_last ? S_N_CHK : S_CH_MUL;
            end
            S_N_CHK:
            begin
                state_next = sts.total_zero ? S_IDLE : S_N_INIT;
            end
            S_N_INIT:
            begin
                cmd.node_init = 1'b1;
                state_next    = S_W0;
            end
            S_W0:
            begin
                cmd.w0     = 1'b1;
                state_next = S_W1;
            end
            S_W1:
            begin
                cmd.w1     = 1'b1;
                state_next = S_STREAM;
            end
            S_STREAM:
            begin
                cmd.issue = 1'b1;
                if (sts.k_last)
                begin
                    state_next = sts.ij_last ? S_DRAIN : S_W0;
                end
            end
            S_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.node_last ? S_IDLE : S_N_INIT;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sim/cte_tb_pkg.sv
// ---------------------------------------------------------------------------
// cte_tb_pkg
// Item and result codes shared by the evaluator checker and its testbench.
// ---------------------------------------------------------------------------
`default_nettype none

package cte_tb_pkg;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_EVAL  = 1'b1;

    localparam logic KIND_AMPLITUDE = 1'b0;
    localparam logic KIND_PHASE     = 1'b1;

endpackage

`default_nettype wire

### sim/chebyshev_tensor_eval_3d_checker.sv
// ---------------------------------------------------------------------------
// chebyshev_tensor_eval_3d_checker
// Watches the item, result and register channels of the evaluator, keeps its
// own copy of the coefficients and registers, and checks every node result.
// ---------------------------------------------------------------------------
`default_nettype none

module chebyshev_tensor_eval_3d_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_stall,
    input  logic                              func,
    input  logic [cte_pkg::ADDR_W-1:0]        coef_address,
    input  logic signed [cte_pkg::COEF_W-1:0] coef_value,
    input  logic [cte_pkg::COORD_W-1:0]       first_coord,
    input  logic [cte_pkg::COORD_W-1:0]       second_coord,
    input  logic [cte_pkg::COORD_W-1:0]       third_coord,
    input  logic                              out_valid,
    input  logic                              out_stall,
    input  logic                              result_kind,
    input  logic [cte_pkg::NODE_W-1:0]        node_number,
    input  logic signed [cte_pkg::VAL_W-1:0]  node_value,
    input  logic                              range_flag,
    input  logic                              last_result,
    input  logic                              cfg_valid,
    input  logic                              cfg_ready,
    input  logic [cte_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cte_pkg::CFG_W-1:0]         cfg_data,
    output int                                error_count,
    output int                                pending_count,
    output int                                checked_count
);
    import cte_pkg::*;
    import cte_tb_pkg::*;

    localparam longint UNIT = longint'(1) << 30;
    localparam longint SUM_HI = (longint'(1) << 47) - 1;
    localparam longint SUM_LO = -(longint'(1) << 47);

    typedef struct packed {
        logic                    kind;
        logic [NODE_W-1:0]       number;
        logic signed [VAL_W-1:0] value;
        logic                    flag;
        logic                    last;
    } node_result_t;

    logic signed [COEF_W-1:0] coef_mirror [0:STORE_DEPTH-1];
    longint unsigned          axis_lo [3];
    longint unsigned          axis_hi [3];
    int                       amp_nodes;
    int                       phase_nodes;
    node_result_t             node_queue [$];

    function automatic longint round_half_away(input longint v, input int s);
        longint h;
        h = longint'(1) << (s - 1);
        if (v >= 0)
            return (v + h) >>> s;
        return -((-v + h) >>> s);
    endfunction

    function automatic longint clip_unit(input longint v);
        if (v > UNIT)
            return UNIT;
        if (v < -UNIT)
            return -UNIT;
        return v;
    endfunction

    // coordinate onto [-1,1] in Q2.30, clamping to the configured range
    function automatic longint map_unit(input longint unsigned c, input longint unsigned lo,
                                        input longint unsigned hi, inout bit clamped);
        longint          num;
        longint unsigned den;
        longint unsigned mag;
        longint          q;
        if (hi <= lo)
        begin
            if (c != lo)
                clamped = 1'b1;
            return 0;
        end
        if (c < lo)
        begin
            c = lo;
            clamped = 1'b1;
        end
        if (c > hi)
        begin
            c = hi;
            clamped = 1'b1;
        end
        num = 2 * longint'(c) - longint'(lo) - longint'(hi);
        den = hi - lo;
        mag = (num < 0) ? longint'(-num) : num;
        q = longint'(((mag << 30) + den / 2) / den);
        return (num < 0) ? -q : q;
    endfunction

    task automatic predict_series(input logic [31:0] cx, input logic [31:0] cy,
                                  input logic [31:0] cz);
        longint unsigned coord [3];
        longint          u [3];
        longint          t [3][MAX_ORDER];
        int              ord [3];
        bit              clamped;
        int              na;
        int              np;
        int              total;
        longint          acc;
        longint          wij;
        longint          w;
        int unsigned     addr;
        node_result_t    r;
        coord[0] = cx;
        coord[1] = cy;
        coord[2] = cz;
        ord[0] = FIRST_ORDER;
        ord[1] = SECOND_ORDER;
        ord[2] = THIRD_ORDER;
        clamped = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            u[a] = map_unit(coord[a], axis_lo[a], axis_hi[a], clamped);
            t[a][0] = UNIT;
            if (ord[a] > 1)
                t[a][1] = u[a];
            for (int n = 2; n < ord[a]; n++)
                t[a][n] = clip_unit(round_half_away(2 * u[a] * t[a][n-1], 30) - t[a][n-2]);
        end
        na = (amp_nodes < NODE_CAP_I) ? amp_nodes : NODE_CAP_I;
        np = (phase_nodes < NODE_CAP_I - na) ? phase_nodes : NODE_CAP_I - na;
        total = na + np;
        for (int n = 0; n < total; n++)
        begin
            acc = 0;
            addr = n * BLOCK;
            for (int i = 0; i < FIRST_ORDER; i++)
                for (int j = 0; j < SECOND_ORDER; j++)
                begin
                    wij = round_half_away(t[0][i] * t[1][j], 30);
                    for (int k = 0; k < THIRD_ORDER; k++)
                    begin
                        w = round_half_away(wij * t[2][k], 30);
                        acc += round_half_away(longint'(coef_mirror[addr % STORE_DEPTH]) * w, 30);
                        addr++;
                    end
                end
            if (acc > SUM_HI)
                acc = SUM_HI;
            if (acc < SUM_LO)
                acc = SUM_LO;
            r.kind   = (n < na) ? KIND_AMPLITUDE : KIND_PHASE;
            r.number = NODE_W'((n < na) ? n : n - na);
            r.value  = acc[VAL_W-1:0];
            r.flag   = clamped;
            r.last   = (n + 1 == total);
            node_queue.push_back(r);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        node_result_t want;
        if (!rst_n)
        begin
            axis_lo[0] = 32768;
            axis_hi[0] = 65536;
            axis_lo[1] = 3276800;
            axis_hi[1] = 327680000;
            axis_lo[2] = 3276800;
            axis_hi[2] = 327680000;
            amp_nodes = 12;
            phase_nodes = 7;
            node_queue.delete();
            error_count = 0;
            checked_count = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                checked_count++;
                if (node_queue.size() == 0)
                begin
                    $error("result transfer with nothing outstanding");
                    error_count++;
                end
                else
                begin
                    want = node_queue.pop_front();
                    if (result_kind !== want.kind)
                    begin
                        $error("result_kind: expected %0d, actual %0d", want.kind, result_kind);
                        error_count++;
                    end
                    if (node_number !== want.number)
                    begin
                        $error("node_number: expected %0d, actual %0d", want.number, node_number);
                        error_count++;
                    end
                    if (node_value !== want.value)
                    begin
                        $error("node_value: expected %0d, actual %0d", want.value, node_value);
                        error_count++;
                    end
                    if (range_flag !== want.flag)
                    begin
                        $error("range_flag: expected %0d, actual %0d", want.flag, range_flag);
                        error_count++;
                    end
                    if (last_result !== want.last)
                    begin
                        $error("last_result: expected %0d, actual %0d", want.last, last_result);
                        error_count++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_X_MIN: axis_lo[0] = cfg_data;
                    REG_X_MAX: axis_hi[0] = cfg_data;
                    REG_Y_MIN: axis_lo[1] = cfg_data;
                    REG_Y_MAX: axis_hi[1] = cfg_data;
                    REG_Z_MIN: axis_lo[2] = cfg_data;
                    REG_Z_MAX: axis_hi[2] = cfg_data;
                    REG_AMP_N: amp_nodes = int'(cfg_data[CNT_W-1:0]);
                    REG_PHS_N: phase_nodes = int'(cfg_data[CNT_W-1:0]);
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                if (func == FUNC_WRITE)
                    coef_mirror[coef_address] = coef_value;
                else
                    predict_series(first_coord, second_coord, third_coord);
            end
        end
        pending_count = node_queue.size();
    end

endmodule

`default_nettype wire

### sim/chebyshev_tensor_eval_3d_top_test.sv
// ---------------------------------------------------------------------------
// chebyshev_tensor_eval_3d_top_test
// Fills the whole coefficient store, then evaluates under a string of
// register settings, directed first and random after, with random gaps and
// receiver stalls; the checker module predicts and compares every result.
// ---------------------------------------------------------------------------
`default_nettype none

module chebyshev_tensor_eval_3d_top_test;
    import cte_pkg::*;
    import cte_tb_pkg::*;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = FUNC_WRITE;
    logic [ADDR_W-1:0]          coef_address = '0;
    logic signed [COEF_W-1:0]   coef_value = '0;
    logic [COORD_W-1:0]         first_coord = '0;
    logic [COORD_W-1:0]         second_coord = '0;
    logic [COORD_W-1:0]         third_coord = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic                       result_kind;
    logic [NODE_W-1:0]          node_number;
    logic signed [VAL_W-1:0]    node_value;
    logic                       range_flag;
    logic                       last_result;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    int error_count;
    int pending_count;
    int checked_count;

    // idling switches for each side, and a copy of the ranges for aiming
    bit          gaps_on = 1'b0;
    bit          stalls_on = 1'b0;
    logic [31:0] range_lo [3];
    logic [31:0] range_hi [3];
    int          write_total = 0;
    int          eval_total = 0;
    int          setting_total = 0;

    chebyshev_tensor_eval_3d_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .coef_address (coef_address),
        .coef_value   (coef_value),
        .first_coord  (first_coord),
        .second_coord (second_coord),
        .third_coord  (third_coord),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .result_kind  (result_kind),
        .node_number  (node_number),
        .node_value   (node_value),
        .range_flag   (range_flag),
        .last_result  (last_result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    chebyshev_tensor_eval_3d_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .coef_address  (coef_address),
        .coef_value    (coef_value),
        .first_coord   (first_coord),
        .second_coord  (second_coord),
        .third_coord   (third_coord),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .node_number   (node_number),
        .node_value    (node_value),
        .range_flag    (range_flag),
        .last_result   (last_result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    initial
    begin
        forever
            #5 clk = ~clk;
    end

    // receiver back-pressure, asserted with a chance of 31 in a hundred when enabled
    always @(posedge clk)
    begin
        out_stall <= stalls_on && ($urandom_range(99) < 31);
    end

    // one item transfer; returns at the edge where it was taken, valid left high
    task automatic send_item(input logic f, input logic [ADDR_W-1:0] addr,
                             input logic [31:0] coef, input logic [31:0] x,
                             input logic [31:0] y, input logic [31:0] z);
        logic held;
        if (gaps_on && $urandom_range(99) < 31)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        func         <= f;
        coef_address <= addr;
        coef_value   <= coef;
        first_coord  <= x;
        second_coord <= y;
        third_coord  <= z;
        // stall sampled mid-cycle, so the decision never races the edge
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end
        while (held);
        if (f == FUNC_WRITE)
            write_total++;
        else
            eval_total++;
    endtask

    task automatic send_eval(input logic [31:0] x, input logic [31:0] y, input logic [31:0] z);
        send_item(FUNC_EVAL, ADDR_W'($urandom), $urandom, x, y, z);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        logic busy;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
        begin
            @(negedge clk);
            busy = !cfg_ready;
            @(posedge clk);
        end
        while (busy);
    endtask

    // all eight registers; counts carry random bits above the six that count
    task automatic apply_setting(input logic [31:0] xl, input logic [31:0] xh,
                                 input logic [31:0] yl, input logic [31:0] yh,
                                 input logic [31:0] zl, input logic [31:0] zh,
                                 input int amp, input int phs);
        range_lo[0] = xl;
        range_hi[0] = xh;
        range_lo[1] = yl;
        range_hi[1] = yh;
        range_lo[2] = zl;
        range_hi[2] = zh;
        write_reg(REG_X_MIN, xl);
        write_reg(REG_X_MAX, xh);
        write_reg(REG_Y_MIN, yl);
        write_reg(REG_Y_MAX, yh);
        write_reg(REG_Z_MIN, zl);
        write_reg(REG_Z_MAX, zh);
        write_reg(REG_AMP_N, ($urandom & ~32'h3f) | (amp & 32'h3f));
        write_reg(REG_PHS_N, ($urandom & ~32'h3f) | (phs & 32'h3f));
        cfg_valid <= 1'b0;
        setting_total++;
    endtask

    // drain: all results home, then room for a zero-node evaluation to finish
    task automatic wait_quiet();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        repeat (400) @(posedge clk);
    endtask

    // mostly inside the range, some on the bounds, some anywhere
    function automatic logic [31:0] aim_coord(input int a);
        longint unsigned span;
        int              r;
        r = $urandom_range(99);
        if (r < 60 && range_hi[a] > range_lo[a])
        begin
            span = longint'(range_hi[a]) - longint'(range_lo[a]) + 1;
            return range_lo[a] + 32'(({$urandom, $urandom}) % span);
        end
        if (r < 85)
            return ($urandom_range(1) ? range_hi[a] : range_lo[a]) + $urandom_range(0, 2)
                   - $urandom_range(0, 2);
        return $urandom;
    endfunction

    task automatic pick_range(output logic [31:0] lo, output logic [31:0] hi);
        logic [31:0] a;
        logic [31:0] b;
        int          m;
        a = $urandom;
        b = $urandom;
        m = $urandom_range(9);
        if (m < 6)
        begin
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
        end
        else if (m < 8)
        begin
            lo = a;
            hi = a + $urandom_range(1, 1000);
        end
        else if (m == 8)
        begin
            lo = a;
            hi = a;
        end
        else
        begin
            lo = a;
            hi = b;
        end
    endtask

    initial
    begin : stimulus
        logic [31:0] lo [3];
        logic [31:0] hi [3];

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // preload every coefficient word, back to back with no gaps
        for (int a = 0; a < STORE_DEPTH; a++)
            send_item(FUNC_WRITE, ADDR_W'(a), $urandom, $urandom, $urandom, $urandom);

        // register defaults: a point inside all three ranges, no stalls
        send_eval(32'd49152, 32'd100 << 16, 32'd4000000);
        wait_quiet();

        // directed: full-width second range, degenerate third range
        gaps_on = 1'b1;
        stalls_on = 1'b1;
        apply_setting(32'h0001_0000, 32'h0005_0000, 32'h0, 32'hffff_ffff,
                      32'h0000_1234, 32'h0000_1234, 1, 1);
        send_eval(32'h0, 32'h0, 32'h0000_1234);
        send_eval(32'hffff_ffff, 32'hffff_ffff, 32'h0000_1234);
        send_eval(32'h0001_0000, 32'h8000_0000, 32'h0000_1234);
        send_eval(32'h0005_0000, 32'h7fff_ffff, 32'h0000_1235);
        send_eval(32'h0003_0000, 32'h0000_0001, 32'hffff_ffff);
        send_eval(32'h0002_8001, 32'hffff_fffe, 32'h0);
        // extreme coefficient words at both ends of the store, then a -1 and a zero word
        send_item(FUNC_WRITE, ADDR_W'(0), 32'h8000_0000, $urandom, $urandom, $urandom);
        send_item(FUNC_WRITE, {ADDR_W{1'b1}}, 32'h7fff_ffff, $urandom, $urandom, $urandom);
        send_item(FUNC_WRITE, ADDR_W'(1), 32'hffff_ffff, $urandom, $urandom, $urandom);
        send_item(FUNC_WRITE, ADDR_W'(4096), 32'h0, $urandom, $urandom, $urandom);
        send_eval(32'h0001_0000, 32'h0, 32'h0000_1234);
        send_eval(32'h0005_0000, 32'hffff_ffff, 32'h0000_1234);
        wait_quiet();

        // reversed first range, then the node count extremes
        apply_setting(32'hffff_ffff, 32'h0, 32'h0, 32'h0000_0001,
                      32'h1000_0000, 32'h2000_0000, 0, 0);
        send_eval(32'hffff_ffff, 32'h0, 32'h1800_0000);
        send_eval(32'h1234_5678, 32'h1, 32'h0);
        wait_quiet();
        apply_setting(32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                      32'h0, 32'hffff_ffff, 63, 63);
        send_eval($urandom, $urandom, $urandom);
        wait_quiet();
        apply_setting(32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff,
                      32'h0, 32'hffff_ffff, 0, 63);
        send_eval(32'h0, 32'hffff_ffff, 32'h8000_0000);
        wait_quiet();

        // random settings, each followed by a mix of writes and evaluations
        for (int s = 0; s < 5; s++)
        begin
            for (int a = 0; a < 3; a++)
                pick_range(lo[a], hi[a]);
            apply_setting(lo[0], hi[0], lo[1], hi[1], lo[2], hi[2],
                          $urandom_range(0, 1), $urandom_range(0, 2));
            for (int n = 0; n < 20; n++)
            begin
                if ($urandom_range(99) < 55)
                    send_item(FUNC_WRITE, ADDR_W'($urandom), $urandom,
                              $urandom, $urandom, $urandom);
                else
                    send_eval(aim_coord(0), aim_coord(1), aim_coord(2));
            end
            wait_quiet();
        end

        $display("run covered %0d coefficient writes and %0d evaluations", write_total, eval_total);
        $display("over %0d register settings, %0d node results checked",
                 setting_total + 1, checked_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial
    begin
        #200000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire
